[hdl/noise_learn_spectral_subtract_assert.svh]
// assertion macros for the noise learning spectral subtraction block
// no dependencies; included by the files that carry assertions
`ifndef NOISE_LEARN_SPECTRAL_SUBTRACT_ASSERT_SVH
`define NOISE_LEARN_SPECTRAL_SUBTRACT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked outside reset
`define NLSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every edge, reset included
`define NLSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NLSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define NLSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/nlss_pkg.sv]
// shared widths, register codes, sequencer states and divider structs
// no dependencies
`default_nettype none

package nlss_pkg;

  localparam int POWER_W       = 32;
  localparam int INDEX_W       = 8;
  localparam int LIMIT_W       = 16;
  localparam int STRENGTH_W    = 16;
  localparam int COUNT_W       = 16;
  localparam int PROD_W        = POWER_W + STRENGTH_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int DIVISOR_W     = COUNT_W + 1;
  localparam int QUOT_W        = POWER_W;
  localparam int STRENGTH_FRAC = 12;
  localparam int SCALED_W      = PROD_W - STRENGTH_FRAC;
  localparam int DIV_STEP_W    = $clog2(QUOT_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int FFT_POINTS_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_FRAME_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_STRENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_FLOOR       = 2'd3;

  localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd4096;
  localparam logic [POWER_W-1:0]    FLOOR_RESET    = 32'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_SCALE,
    ST_SUB,
    ST_DONE
  } nlss_state_t;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_stat_t;

endpackage

`default_nettype wire

[hdl/nlss_if.sv]
// valid/ready channel interfaces for bin requests and results
// depends on nlss_pkg
`default_nettype none

interface nlss_in_if import nlss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] bin_power;
  logic [INDEX_W-1:0] bin_index;

  modport source (output valid, output bin_power, output bin_index, input ready);
  modport sink   (input valid, input bin_power, input bin_index, output ready);
endinterface

interface nlss_out_if import nlss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] power_out;
  logic               was_learning;
  logic               was_subtracted;

  modport source (output valid, output power_out, output was_learning,
                  output was_subtracted, input ready);
  modport sink   (input valid, input power_out, input was_learning,
                  input was_subtracted, output ready);
endinterface

`default_nettype wire

[hdl/nlss_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module nlss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 129
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/nlss_div.sv]
// restoring divider, one quotient bit per cycle
// depends on nlss_pkg; quotient must fit in QUOT_W bits
`default_nettype none

module nlss_div import nlss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire div_req_t  req,
  output      div_stat_t stat
);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIV_STEP_W-1:0] cnt_r;
  logic                  busy_r, done_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // dividend high part is below the divisor, so only the low bits need steps
  always_comb begin
    trial   = {rem_r, quo_r[QUOT_W-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, div_r}) : trial[DIVISOR_W-1:0];
    quo_nxt = {quo_r[QUOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_STEP_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[SUM_W-1:QUOT_W];
      quo_r <= req.dividend[QUOT_W-1:0];
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

`default_nettype wire

[hdl/noise_learn_spectral_subtract.sv]
// top level: sequencer, shared multiplier, noise estimate ram and divider
// depends on nlss_pkg, nlss_if, nlss_ram, nlss_div and the assertion header
//
// Takes one power bin (unsigned Q16.16) per request, tagged with its bin index,
// and returns one result per request. After reset the block sweeps the noise
// estimate ram to zero, one entry a cycle, FFT_POINTS/2+1 entries in all (129 at
// the default), and takes no request meanwhile; configuration writes are taken
// at any time. Then one bin is worked at a time: a bin that passes through
// (disabled or index out of range) goes straight to the output stage, a bin
// that is only subtracted takes a ram read, one pass of the shared multiplier
// and the compare, and a learning bin takes the ram read, a multiplier pass and
// the bit-serial divider that forms the running mean, one quotient bit a cycle,
// then the scale and the compare as well when it is subtracted.
// The result sits in an output register, so the next request is taken while
// it waits. Subtraction scales the estimate by a Q4.12 strength and floors the difference at
// power_floor. Configuration is to be written only while idle; the block does not enforce it.
`default_nettype none
`include "noise_learn_spectral_subtract_assert.svh"

module noise_learn_spectral_subtract import nlss_pkg::*; #(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  nlss_in_if.sink                    in_bin,
  nlss_out_if.source                 out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int EST_DEPTH = FFT_POINTS / 2 + 1;
  localparam int LAST_BIN  = FFT_POINTS / 2;
  localparam int AW        = $clog2(EST_DEPTH);

  // configuration registers
  logic                  enable_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [STRENGTH_W-1:0] strength_r;
  logic [POWER_W-1:0]    floor_r;

  nlss_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] count_r;
  logic [AW-1:0]      clr_addr_r;

  // per-request working registers
  logic [POWER_W-1:0] power_r;
  logic [INDEX_W-1:0] idx_r;
  logic               learn_r;
  logic               sub_r;
  logic [POWER_W-1:0] noise_r;
  logic [PROD_W-1:0]  prod_r;
  logic [POWER_W-1:0] result_r;

  // result register
  logic               out_valid_r;
  logic [POWER_W-1:0] out_power_r;
  logic               out_learn_r;
  logic               out_sub_r;

  logic               accept;
  logic               active;
  logic               learn_now;
  logic [COUNT_W:0]   effective;
  logic               sub_now;
  logic               last_bin;
  logic               out_free;

  logic [STRENGTH_W-1:0] mul_b;
  logic [PROD_W-1:0]     mul_out;
  logic [SCALED_W-1:0]   scaled;
  logic [POWER_W-1:0]    diff;
  logic [POWER_W-1:0]    sub_result;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [POWER_W-1:0] ram_wdata;
  logic [POWER_W-1:0] ram_rdata;

  div_req_t  div_req;
  div_stat_t div_stat;

  // request decode against the current registers
  assign accept    = in_bin.valid && in_bin.ready;
  assign active    = enable_r && (32'(in_bin.bin_index) <= 32'(LAST_BIN));
  assign learn_now = count_r < limit_r;
  assign effective = learn_now ? ({1'b0, count_r} + 1'b1) : {1'b0, count_r};
  assign sub_now   = effective >= {1'b0, limit_r};
  assign last_bin  = 32'(idx_r) == 32'(LAST_BIN);
  assign out_free  = !out_valid_r || out_res.ready;

  assign in_bin.ready = state_r == ST_IDLE;

  // shared multiplier: estimate times count for the mean, times strength for the scale
  assign mul_b   = (state_r == ST_MUL) ? count_r : strength_r;
  assign mul_out = PROD_W'(noise_r) * PROD_W'(mul_b);

  // subtraction and floor
  always_comb begin
    scaled = prod_r[PROD_W-1:STRENGTH_FRAC];
    diff   = power_r - scaled[POWER_W-1:0];
    if (scaled >= SCALED_W'(power_r)) begin
      sub_result = floor_r;
    end else if (diff < floor_r) begin
      sub_result = floor_r;
    end else begin
      sub_result = diff;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      limit_r    <= '0;
      strength_r <= STRENGTH_RESET;
      floor_r    <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUBTRACT_ENABLE:   enable_r   <= cfg_wdata[0];
        CFG_LEARN_FRAME_LIMIT: limit_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_SUBTRACT_STRENGTH: strength_r <= cfg_wdata[STRENGTH_W-1:0];
        CFG_POWER_FLOOR:       floor_r    <= cfg_wdata[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(EST_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = active ? ST_READ : ST_DONE;
      end
      ST_READ:   state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = learn_r ? ST_MUL : ST_SCALE;
      ST_MUL:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) state_nxt = sub_r ? ST_SCALE : ST_DONE;
      end
      ST_SCALE:  state_nxt = ST_SUB;
      ST_SUB:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer outputs: ram write port and divider start
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = AW'(idx_r);
    ram_wdata        = div_stat.quotient;
    div_req.start    = 1'b0;
    div_req.dividend = SUM_W'(prod_r) + SUM_W'(power_r);
    div_req.divisor  = DIVISOR_W'(count_r) + 1'b1;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_DIV_GO: div_req.start = 1'b1;
      ST_DIV:    ram_we = div_stat.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      count_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      // frame count moves on when the last bin of a learning frame is folded in
      if (state_r == ST_DIV && div_stat.done && last_bin) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          power_r  <= in_bin.bin_power;
          idx_r    <= in_bin.bin_index;
          learn_r  <= active && learn_now;
          sub_r    <= active && sub_now;
          result_r <= in_bin.bin_power;
        end
      end
      ST_FETCH:  noise_r <= ram_rdata;
      ST_MUL:    prod_r  <= mul_out;
      ST_DIV: begin
        if (div_stat.done) noise_r <= div_stat.quotient;
      end
      ST_SCALE:  prod_r   <= mul_out;
      ST_SUB:    result_r <= sub_result;
      default: ;
    endcase
  end

  // result register, loaded while an older result may still be draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_power_r <= result_r;
      out_learn_r <= learn_r;
      out_sub_r   <= sub_r;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.power_out      = out_power_r;
  assign out_res.was_learning   = out_learn_r;
  assign out_res.was_subtracted = out_sub_r;

  nlss_ram #(
    .WIDTH (POWER_W),
    .DEPTH (EST_DEPTH)
  ) u_noise_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata)
  );

  nlss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  // checks on the sequencer
  `NLSS_ASSERT(a_div_done_in_wait, clk, rst_n, div_stat.done |-> state_r == ST_DIV, "divider done outside wait state")
  `NLSS_ASSERT(a_no_request_in_clear, clk, rst_n, state_r == ST_CLEAR |-> !in_bin.ready, "request taken during clear")
  `NLSS_ASSERT(a_ram_write_phase, clk, rst_n, ram_we |-> (state_r == ST_CLEAR || state_r == ST_DIV), "ram written outside clear or mean update")
  `NLSS_ASSERT(a_count_moves_on_learn, clk, rst_n, (count_r != $past(count_r)) |-> $past(div_stat.done && learn_r), "frame count changed without learning")
  `NLSS_ASSERT(a_learn_starts_divider, clk, rst_n, (state_r == ST_DIV_GO) |=> div_stat.busy, "divider not busy after start")

endmodule

`default_nettype wire
